@@ rtl/core/csts_pkg.sv @@
// Shared constants, types and saturation helpers for the cubic spline step block.
package csts_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int Q_BITS        = 62;
    localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic        [30:0] t;
        logic               fault;
    } t_side1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic               fault;
        logic signed [63:0] c2;
    } t_side2;

    typedef struct packed {
        logic signed [63:0] pos;
        logic signed [63:0] vel;
        logic signed [63:0] acc;
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic               fault;
    } t_res;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIM)) return LIM;
        if (s < -65'(LIM)) return -LIM;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] a);
        if (a > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (a < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
        return a[31:0];
    endfunction

endpackage

@@ rtl/core/csts_if.sv @@
// Request and result channel interfaces of the cubic spline step block.
interface csts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cur_pos;
    logic signed [31:0] cur_vel;
    logic signed [31:0] goal_pos;
    logic signed [31:0] goal_vel;
    logic        [30:0] time_left;

    modport source (output valid, cur_pos, cur_vel, goal_pos, goal_vel, time_left,
                    input ready);
    modport sink   (input valid, cur_pos, cur_vel, goal_pos, goal_vel, time_left,
                    output ready);
endinterface

interface csts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_pos;
    logic signed [31:0] next_vel;
    logic signed [31:0] next_acc;
    logic               divide_fault;

    modport source (output valid, next_pos, next_vel, next_acc, divide_fault,
                    input ready);
    modport sink   (input valid, next_pos, next_vel, next_acc, divide_fault,
                    output ready);
endinterface

@@ rtl/core/csts_front.sv @@
// Front stages: differences, velocity-time products and coefficient numerators.
module csts_front import csts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int N_W = 66 - FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic signed [31:0]    i_cur_pos,
    input  logic signed [31:0]    i_cur_vel,
    input  logic signed [31:0]    i_goal_pos,
    input  logic signed [31:0]    i_goal_vel,
    input  logic        [30:0]    i_time_left,
    output logic                  o_vld,
    output logic signed [N_W-1:0] o_n2,
    output logic signed [N_W-1:0] o_n3,
    output logic        [61:0]    o_tsq,
    output t_side1                o_side
);

    logic               r1_vld, r2_vld, r3_vld;
    logic signed [32:0] r1_d;
    logic signed [33:0] r1_s1;
    logic signed [32:0] r1_s2;
    logic        [30:0] r1_t;
    t_side1             r1_side;

    logic        [32:0] m1, m2;
    logic        [63:0] r2_p1, r2_p2;
    logic        [61:0] r2_tsq;
    logic               r2_n1, r2_n2;
    logic signed [32:0] r2_d;
    t_side1             r2_side;

    logic        [63:0] sh1, sh2;
    logic signed [N_W-1:0] sv1, sv2, dx;
    logic signed [N_W-1:0] r3_n2, r3_n3;
    logic        [61:0] r3_tsq;
    t_side1             r3_side;

    assign m1  = r1_s1[33] ? 33'(-r1_s1) : 33'(r1_s1);
    assign m2  = r1_s2[32] ? 33'(-r1_s2) : 33'(r1_s2);
    assign sh1 = r2_p1 >> FRAC_BITS;
    assign sh2 = r2_p2 >> FRAC_BITS;
    assign sv1 = r2_n1 ? -N_W'(sh1) : N_W'(sh1);
    assign sv2 = r2_n2 ? -N_W'(sh2) : N_W'(sh2);
    assign dx  = N_W'(r2_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= 33'(i_goal_pos) - 33'(i_cur_pos);
            r1_s1   <= 34'(i_cur_vel) + 34'(i_cur_vel) + 34'(i_goal_vel);
            r1_s2   <= 33'(i_cur_vel) + 33'(i_goal_vel);
            r1_t    <= i_time_left;
            r1_side <= '{x: i_cur_pos, v: i_cur_vel, t: i_time_left,
                         fault: (i_time_left == '0)};

            r2_p1   <= m1 * r1_t;
            r2_p2   <= m2 * r1_t;
            r2_tsq  <= r1_t * r1_t;
            r2_n1   <= r1_s1[33];
            r2_n2   <= r1_s2[32];
            r2_d    <= r1_d;
            r2_side <= r1_side;

            r3_n2   <= dx + dx + dx - sv1;
            r3_n3   <= sv2 - (dx + dx);
            r3_tsq  <= r2_tsq;
            r3_side <= r2_side;
        end
    end

    assign o_vld  = r3_vld;
    assign o_n2   = r3_n2;
    assign o_n3   = r3_n3;
    assign o_tsq  = r3_tsq;
    assign o_side = r3_side;

endmodule

@@ rtl/core/csts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, shared divisor across lanes.
module csts_div import csts_pkg::*; #(
    parameter int A_W    = 64,
    parameter int UP     = 16,
    parameter int D_W    = 31,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1,
    localparam int N_W   = A_W + UP,
    localparam int HI_W  = N_W - Q_BITS,
    localparam int CW    = (HI_W > D_W) ? HI_W : D_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [LANES-1:0][A_W-1:0]   i_a,
    input  logic [D_W-1:0]              i_d,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][63:0]      o_q,
    output logic [SIDE_W-1:0]           o_side
);

    logic [LANES-1:0][A_W-1:0] pre_mag;
    logic [LANES-1:0][N_W-1:0] pre_n;
    logic [LANES-1:0]          pre_ovf;

    logic [D_W-1:0]    r_rem [0:Q_BITS][LANES];
    logic [Q_BITS-1:0] r_low [0:Q_BITS][LANES];
    logic [Q_BITS-1:0] r_quo [0:Q_BITS][LANES];
    logic              r_sgn [0:Q_BITS][LANES];
    logic              r_ovf [0:Q_BITS][LANES];
    logic [D_W-1:0]    r_dv  [0:Q_BITS];
    logic [SIDE_W-1:0] r_sd  [0:Q_BITS];
    logic [Q_BITS:0]   r_vld;

    logic [D_W:0]      s_tr  [1:Q_BITS][LANES];
    logic              s_ge  [1:Q_BITS][LANES];
    logic signed [63:0] s_val [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            pre_mag[l] = i_a[l][A_W-1] ? A_W'(-$signed(i_a[l])) : i_a[l];
            pre_n[l]   = N_W'(pre_mag[l]) << UP;
            pre_ovf[l] = CW'(pre_n[l] >> Q_BITS) >= CW'(i_d);
        end
    end

    always_comb begin
        for (int k = 1; k <= Q_BITS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                s_tr[k][l] = {r_rem[k-1][l], r_low[k-1][l][Q_BITS-1]};
                s_ge[k][l] = s_tr[k][l] >= {1'b0, r_dv[k-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_BITS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= i_d;
            r_sd[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= pre_ovf[l] ? '0 : D_W'(pre_n[l] >> Q_BITS);
                r_low[0][l] <= pre_n[l][Q_BITS-1:0];
                r_quo[0][l] <= '0;
                r_sgn[0][l] <= i_a[l][A_W-1];
                r_ovf[0][l] <= pre_ovf[l];
            end
            for (int k = 1; k <= Q_BITS; k++) begin
                r_dv[k] <= r_dv[k-1];
                r_sd[k] <= r_sd[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= s_ge[k][l] ? D_W'(s_tr[k][l] - {1'b0, r_dv[k-1]})
                                              : D_W'(s_tr[k][l]);
                    r_low[k][l] <= r_low[k-1][l] << 1;
                    r_quo[k][l] <= {r_quo[k-1][l][Q_BITS-2:0], s_ge[k][l]};
                    r_sgn[k][l] <= r_sgn[k-1][l];
                    r_ovf[k][l] <= r_ovf[k-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s_val[l] = r_ovf[Q_BITS][l] ? LIM : $signed(64'(r_quo[Q_BITS][l]));
            o_q[l]   = r_sgn[Q_BITS][l] ? -s_val[l] : s_val[l];
        end
    end

    assign o_vld  = r_vld[Q_BITS];
    assign o_side = r_sd[Q_BITS];

endmodule

@@ rtl/core/csts_mul.sv @@
// Three-stage saturating multiply by an unsigned factor with a right shift.
module csts_mul import csts_pkg::*; #(
    parameter int M_W  = 17,
    parameter int SH   = 16,
    localparam int MH  = (M_W + 1) / 2,
    localparam int MP_W = 2 * MH,
    localparam int P_W = 64 + MP_W
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic [M_W-1:0]     i_m,
    output logic signed [63:0] o_p
);

    logic [62:0]        mag;
    logic [MP_W-1:0]    mp;
    logic [31+MH:0]     r_pp00, r_pp01;
    logic [30+MH:0]     r_pp10, r_pp11;
    logic               r_s1, r_s2;
    logic [P_W-1:0]     r_sum;
    logic [P_W-1:0]     shv;
    logic signed [63:0] val;
    logic signed [63:0] r_p;

    assign mag = i_a[63] ? 63'(-i_a) : 63'(i_a);
    assign mp  = MP_W'(i_m);
    assign shv = r_sum >> SH;
    assign val = (shv > P_W'(LIM)) ? LIM : $signed(shv[63:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00 <= mag[31:0]  * mp[MH-1:0];
            r_pp01 <= mag[31:0]  * mp[MP_W-1:MH];
            r_pp10 <= mag[62:32] * mp[MH-1:0];
            r_pp11 <= mag[62:32] * mp[MP_W-1:MH];
            r_s1   <= i_a[63];

            r_sum  <= P_W'(r_pp00) + (P_W'(r_pp01) << MH) + (P_W'(r_pp10) << 32)
                    + (P_W'(r_pp11) << (32 + MH));
            r_s2   <= r_s1;

            r_p    <= r_s2 ? -val : val;
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/core/csts_back.sv @@
// Back stages: evaluate the cubic at one time step and accumulate with saturation.
module csts_back import csts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int TS_W = FRAC_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic signed [63:0]    i_c3,
    input  t_side2                i_side,
    input  logic [TS_W-1:0]       i_h,
    input  logic [2*TS_W-1:0]     i_h2,
    input  logic [3*TS_W-1:0]     i_h3,
    input  logic [TS_W:0]         i_h2x,
    input  logic [2*TS_W+1:0]     i_h2x3,
    input  logic [TS_W+2:0]       i_h6,
    output logic                  o_vld,
    output t_res                  o_res
);

    logic signed [63:0] v64;
    logic signed [63:0] t_vh, t_c2h2, t_c3h3, t_c2h, t_c3h2, t_c3h;

    logic signed [31:0] r_m_x  [3];
    logic signed [31:0] r_m_v  [3];
    logic               r_m_f  [3];
    logic signed [63:0] r_m_a2 [3];
    logic [2:0]         r_m_vld;

    logic               r1_vld, r2_vld, r3_vld;
    logic signed [63:0] r1_pos, r1_vel, r1_acc, r1_t2, r1_t3, r1_u3;
    logic signed [63:0] r2_pos, r2_vel, r2_acc, r2_t3;
    logic signed [63:0] r3_pos, r3_vel, r3_acc;
    logic signed [31:0] r1_x, r1_v, r2_x, r2_v, r3_x, r3_v;
    logic               r1_f, r2_f, r3_f;

    assign v64 = {{32{i_side.v[31]}}, i_side.v};

    csts_mul #(.M_W(TS_W), .SH(FRAC_BITS)) u_mul_vh (
        .i_clk, .i_en, .i_a(v64), .i_m(i_h), .o_p(t_vh));
    csts_mul #(.M_W(2*TS_W), .SH(2*FRAC_BITS)) u_mul_c2h2 (
        .i_clk, .i_en, .i_a(i_side.c2), .i_m(i_h2), .o_p(t_c2h2));
    csts_mul #(.M_W(3*TS_W), .SH(3*FRAC_BITS)) u_mul_c3h3 (
        .i_clk, .i_en, .i_a(i_c3), .i_m(i_h3), .o_p(t_c3h3));
    csts_mul #(.M_W(TS_W+1), .SH(FRAC_BITS)) u_mul_c2h (
        .i_clk, .i_en, .i_a(i_side.c2), .i_m(i_h2x), .o_p(t_c2h));
    csts_mul #(.M_W(2*TS_W+2), .SH(2*FRAC_BITS)) u_mul_c3h2 (
        .i_clk, .i_en, .i_a(i_c3), .i_m(i_h2x3), .o_p(t_c3h2));
    csts_mul #(.M_W(TS_W+3), .SH(FRAC_BITS)) u_mul_c3h (
        .i_clk, .i_en, .i_a(i_c3), .i_m(i_h6), .o_p(t_c3h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= '0;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
        end else if (i_en) begin
            r_m_vld <= {r_m_vld[1:0], i_vld};
            r1_vld  <= r_m_vld[2];
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_x[0]  <= i_side.x;
            r_m_v[0]  <= i_side.v;
            r_m_f[0]  <= i_side.fault;
            r_m_a2[0] <= sat_add(i_side.c2, i_side.c2);
            for (int k = 1; k < 3; k++) begin
                r_m_x[k]  <= r_m_x[k-1];
                r_m_v[k]  <= r_m_v[k-1];
                r_m_f[k]  <= r_m_f[k-1];
                r_m_a2[k] <= r_m_a2[k-1];
            end

            r1_pos <= sat_add({{32{r_m_x[2][31]}}, r_m_x[2]}, t_vh);
            r1_vel <= sat_add({{32{r_m_v[2][31]}}, r_m_v[2]}, t_c2h);
            r1_acc <= sat_add(r_m_a2[2], t_c3h);
            r1_t2  <= t_c2h2;
            r1_t3  <= t_c3h3;
            r1_u3  <= t_c3h2;
            r1_x   <= r_m_x[2];
            r1_v   <= r_m_v[2];
            r1_f   <= r_m_f[2];

            r2_pos <= sat_add(r1_pos, r1_t2);
            r2_vel <= sat_add(r1_vel, r1_u3);
            r2_acc <= r1_acc;
            r2_t3  <= r1_t3;
            r2_x   <= r1_x;
            r2_v   <= r1_v;
            r2_f   <= r1_f;

            r3_pos <= sat_add(r2_pos, r2_t3);
            r3_vel <= r2_vel;
            r3_acc <= r2_acc;
            r3_x   <= r2_x;
            r3_v   <= r2_v;
            r3_f   <= r2_f;
        end
    end

    assign o_vld = r3_vld;
    assign o_res = '{pos: r3_pos, vel: r3_vel, acc: r3_acc, x: r3_x, v: r3_v, fault: r3_f};

endmodule

@@ rtl/core/cubic_spline_trajectory_step.sv @@
// Top level of the cubic spline trajectory step pipeline.
// Usage:
//   i_in carries one request per handshake: current and goal position and velocity
//   plus the time left, all signed Q16.16 (time unsigned). o_out returns one result
//   per request, in order: position, velocity and acceleration one time step ahead,
//   saturated to 32 bits, plus divide_fault when the time left was zero.
//   i_cfg_we / i_cfg_wdata load the time step; write it only while the block is empty.
// Pipeline: front stages, then two restoring dividers with 62 quotient stages each
//   (one quotient bit per stage), then multiply, sum and output stages.
// Throughput: one request per cycle while o_out is taken.
// Reset: clears all valid bits and loads the time step with about 0.01 s.
// Stall: when a result waits and o_out.ready is low, the whole pipeline holds
//   and i_in.ready drops; nothing is dropped or repeated.
module cubic_spline_trajectory_step import csts_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csts_in_if.sink            i_in,
    csts_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [FRAC_BITS:0] i_cfg_wdata
);

    localparam int TS_W     = FRAC_BITS + 1;
    localparam int N_W      = 66 - FRAC_BITS;
    localparam int H2_W     = 2 * TS_W;
    localparam int H3_W     = 3 * TS_W;
    localparam int H2X_W    = TS_W + 1;
    localparam int H2X3_W   = 2 * TS_W + 2;
    localparam int H6_W     = TS_W + 3;
    localparam int TS_RESET = (2 ** FRAC_BITS) / 100;

    logic                en;
    logic [TS_W-1:0]     r_time_step;
    logic [H2_W-1:0]     r_h2;
    logic [H3_W-1:0]     r_h3;
    logic [H2X_W-1:0]    r_h2x;
    logic [H2X3_W-1:0]   r_h2x3;
    logic [H6_W-1:0]     r_h6;

    logic                fr_vld;
    logic signed [N_W-1:0] fr_n2, fr_n3;
    logic [61:0]         fr_tsq;
    t_side1              fr_side;

    logic [1:0][N_W-1:0] d1_a;
    logic                d1_vld;
    logic [1:0][63:0]    d1_q;
    t_side1              d1_side;

    logic [0:0][63:0]    d2_a;
    t_side2              d2_side_in;
    logic                d2_vld;
    logic [0:0][63:0]    d2_q;
    t_side2              d2_side;

    logic                bk_vld;
    t_res                bk_res;

    logic                r_out_vld;
    logic signed [31:0]  r_out_pos, r_out_vel, r_out_acc;
    logic                r_out_fault;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TS_W'(TS_RESET);
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h2   <= H2_W'(r_time_step) * H2_W'(r_time_step);
        r_h3   <= H3_W'(r_h2) * H3_W'(r_time_step);
        r_h2x  <= {r_time_step, 1'b0};
        r_h2x3 <= H2X3_W'(r_h2) + H2X3_W'({r_h2, 1'b0});
        r_h6   <= H6_W'({r_time_step, 2'b00}) + H6_W'({r_time_step, 1'b0});
    end

    csts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk,
        .i_rst_n,
        .i_en        (en),
        .i_vld       (i_in.valid),
        .i_cur_pos   (i_in.cur_pos),
        .i_cur_vel   (i_in.cur_vel),
        .i_goal_pos  (i_in.goal_pos),
        .i_goal_vel  (i_in.goal_vel),
        .i_time_left (i_in.time_left),
        .o_vld       (fr_vld),
        .o_n2        (fr_n2),
        .o_n3        (fr_n3),
        .o_tsq       (fr_tsq),
        .o_side      (fr_side)
    );

    assign d1_a[0] = fr_n2;
    assign d1_a[1] = fr_n3;

    csts_div #(
        .A_W(N_W), .UP(2*FRAC_BITS), .D_W(62), .LANES(2), .SIDE_W($bits(t_side1))
    ) u_div_tsq (
        .i_clk,
        .i_rst_n,
        .i_en   (en),
        .i_vld  (fr_vld),
        .i_a    (d1_a),
        .i_d    (fr_tsq),
        .i_side (fr_side),
        .o_vld  (d1_vld),
        .o_q    (d1_q),
        .o_side (d1_side)
    );

    assign d2_a[0]    = d1_q[1];
    assign d2_side_in = '{x: d1_side.x, v: d1_side.v, fault: d1_side.fault,
                          c2: $signed(d1_q[0])};

    csts_div #(
        .A_W(64), .UP(FRAC_BITS), .D_W(31), .LANES(1), .SIDE_W($bits(t_side2))
    ) u_div_t (
        .i_clk,
        .i_rst_n,
        .i_en   (en),
        .i_vld  (d1_vld),
        .i_a    (d2_a),
        .i_d    (d1_side.t),
        .i_side (d2_side_in),
        .o_vld  (d2_vld),
        .o_q    (d2_q),
        .o_side (d2_side)
    );

    csts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk,
        .i_rst_n,
        .i_en   (en),
        .i_vld  (d2_vld),
        .i_c3   ($signed(d2_q[0])),
        .i_side (d2_side),
        .i_h    (r_time_step),
        .i_h2   (r_h2),
        .i_h3   (r_h3),
        .i_h2x  (r_h2x),
        .i_h2x3 (r_h2x3),
        .i_h6   (r_h6),
        .o_vld  (bk_vld),
        .o_res  (bk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= bk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pos   <= bk_res.fault ? bk_res.x : clamp32(bk_res.pos);
            r_out_vel   <= bk_res.fault ? bk_res.v : clamp32(bk_res.vel);
            r_out_acc   <= bk_res.fault ? '0 : clamp32(bk_res.acc);
            r_out_fault <= bk_res.fault;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.next_pos     = r_out_pos;
    assign o_out.next_vel     = r_out_vel;
    assign o_out.next_acc     = r_out_acc;
    assign o_out.divide_fault = r_out_fault;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result held");

    a_fault_zero_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_fault) |-> (o_out.next_acc == '0))
        else $error("fault result carries acceleration");

    a_h2_tracks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_time_step) == r_time_step)
            |-> (r_h2 == H2_W'(r_time_step) * H2_W'(r_time_step)))
        else $error("squared time step out of date");

endmodule

@@ tb/csts_checker.sv @@
// Checker for the cubic spline step block: predicts each result and compares it.
module csts_checker import csts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csts_in_if          i_in,
    csts_out_if         o_out,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int F = 16;
    localparam logic signed [127:0] BOUND = 128'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               fault;
    } t_step;

    t_step       step_q[$];
    logic [16:0] step_size;
    int          fails;

    function automatic logic signed [63:0] lim62(input logic signed [127:0] a);
        if (a > BOUND) return BOUND[63:0];
        if (a < -BOUND) return -BOUND[63:0];
        return a[63:0];
    endfunction

    function automatic logic signed [63:0] mul_shr(input logic signed [63:0] a,
                                                   input logic [63:0] m, input int sh);
        logic [127:0] mg;
        logic [127:0] p;
        logic signed [127:0] r;
        mg = a < 0 ? 128'(-a) : 128'(a);
        p = (mg * 128'(m)) >> sh;
        r = (p > 128'(BOUND)) ? BOUND : $signed(p);
        return a < 0 ? -r[63:0] : r[63:0];
    endfunction

    function automatic logic signed [63:0] div_up(input logic signed [63:0] a,
                                                  input int up, input logic [63:0] d);
        logic [127:0] mg;
        logic [127:0] q;
        logic signed [127:0] r;
        mg = (a < 0 ? 128'(-a) : 128'(a)) << up;
        q = mg / 128'(d);
        r = (q > 128'(BOUND)) ? BOUND : $signed(q);
        return a < 0 ? -r[63:0] : r[63:0];
    endfunction

    function automatic logic signed [31:0] to32(input logic signed [63:0] a);
        if (a > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (a < -64'sh8000_0000) return 32'sh8000_0000;
        return a[31:0];
    endfunction

    function automatic t_step predict_step(input logic signed [31:0] x,
            input logic signed [31:0] v, input logic signed [31:0] g,
            input logic signed [31:0] w, input logic [30:0] t, input logic [16:0] hs);
        t_step r;
        logic signed [63:0] xx, vv, d, n2, n3, c2, c3, pos, vel, acc;
        logic [63:0] h, h2, h3, tt;
        xx = x; vv = v; h = hs; h2 = h * h; h3 = h2 * h; tt = t;
        if (t == 0) begin
            r.pos = x; r.vel = v; r.acc = 0; r.fault = 1'b1;
            return r;
        end
        d = 64'(g) - xx;
        n2 = lim62(128'(3 * d) - 128'(mul_shr(2 * vv + w, tt, F)));
        n3 = lim62(128'(mul_shr(vv + w, tt, F)) - 128'(2 * d));
        c2 = div_up(n2, 2 * F, tt * tt);
        c3 = div_up(div_up(n3, 2 * F, tt * tt), F, tt);
        pos = lim62(128'(xx) + 128'(mul_shr(vv, h, F)));
        pos = lim62(128'(pos) + 128'(mul_shr(c2, h2, 2 * F)));
        pos = lim62(128'(pos) + 128'(mul_shr(c3, h3, 3 * F)));
        vel = lim62(128'(vv) + 128'(mul_shr(c2, 2 * h, F)));
        vel = lim62(128'(vel) + 128'(mul_shr(c3, 3 * h2, 2 * F)));
        acc = lim62(128'(mul_shr(c2, 2, 0)) + 128'(mul_shr(c3, 6 * h, F)));
        r.pos = to32(pos); r.vel = to32(vel); r.acc = to32(acc); r.fault = 1'b0;
        return r;
    endfunction

    assign o_fail_count = fails;
    assign o_pending = step_q.size();

    always @(posedge i_clk) begin
        t_step want;
        t_step got;
        if (!i_rst_n) begin
            step_size <= 17'd655;
            fails = 0;
            step_q.delete();
        end else begin
            if (i_cfg_we) step_size <= i_cfg_wdata;
            if (i_in.valid && i_in.ready)
                step_q.push_back(predict_step(i_in.cur_pos, i_in.cur_vel, i_in.goal_pos,
                    i_in.goal_vel, i_in.time_left, step_size));
            if (o_out.valid && o_out.ready) begin
                got = {o_out.next_pos, o_out.next_vel, o_out.next_acc, o_out.divide_fault};
                if (step_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", got);
                end else begin
                    want = step_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp pos %h vel %h acc %h flt %b, got pos %h vel %h acc %h flt %b",
                                want.pos, want.vel, want.acc, want.fault,
                                got.pos, got.vel, got.acc, got.fault);
                    end
                end
            end
        end
    end
endmodule

@@ tb/cubic_spline_trajectory_step_tb.sv @@
// Testbench top for the cubic spline step block: stimulus, pacing and verdict.
module cubic_spline_trajectory_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          quiet = 0;
    bit          timed_out = 0;

    csts_in_if  req_if ();
    csts_out_if res_if ();

    cubic_spline_trajectory_step DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_if.sink), .o_out(res_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    csts_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_if), .o_out(res_if),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.cur_pos = '0; req_if.cur_vel = '0;
        req_if.goal_pos = '0; req_if.goal_vel = '0; req_if.time_left = '0;
        res_if.ready = 1'b0;
    end

    always @(negedge i_clk) res_if.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000 && !timed_out) begin
            timed_out = 1;
            $display("[cubic_spline_trajectory_step] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_t();
        case ($urandom_range(7))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(1, 16));
            3: return 31'($urandom);
            default: return 31'($urandom_range(1, 32'h0010_0000));
        endcase
    endfunction

    task automatic send_request(input logic [31:0] x, input logic [31:0] v,
                                input logic [31:0] g, input logic [31:0] w,
                                input logic [30:0] t);
        if ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle);
        end
        req_if.valid <= 1'b1;
        req_if.cur_pos <= x; req_if.cur_vel <= v;
        req_if.goal_pos <= g; req_if.goal_vel <= w; req_if.time_left <= t;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_and_load(input logic [16:0] step);
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= step;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [16:0] steps[6];
        int k;
        steps = '{17'd1, 17'h10000, 17'd0, 17'h1FFFF, 17'd655, 17'd3277};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_request(0, 0, 32'h0001_0000, 0, 31'h0001_0000);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'd1);
        send_request(32'h1234_5678, 32'hFFFF_0000, 32'h0, 32'h5, 31'd0);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        send_request(32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_request(32'h0002_0000, 32'hFFFF_8000, 32'hFFFE_0000, 32'h0000_8000, 31'h0000_8000);
        for (k = 0; k < 6; k++) begin
            drain_and_load(steps[k]);
            send_request(32'h0001_0000, 32'h0000_4000, 32'h0003_0000, 32'hFFFF_0000,
                         31'h0002_0000);
            send_request(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 31'd3);
        end
        for (k = 0; k < 1550; k++) begin
            if (k == 520) begin send_idle = 52; recv_idle = 38; end
            else if (k == 1040) begin send_idle = 0; recv_idle = 0; end
            else if (k == 0) begin send_idle = 38; recv_idle = 52; end
            if (k % 260 == 259)
                drain_and_load(17'($urandom_range(0, 17'h1FFFF) >> $urandom_range(16)));
            send_request(pick32(), pick32(), pick32(), pick32(), pick_t());
        end
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[cubic_spline_trajectory_step] OK");
        else
            $display("[cubic_spline_trajectory_step] ERROR");
        $finish;
    end
endmodule
